>>> hw/rtl/ncd_pkg.sv
// ncd_pkg: shared constants and types of the negative cycle detector
// no dependencies

package ncd_pkg;

	localparam int MAX_VERTICES = 512;
	localparam int MAX_EDGES    = 8192;
	localparam int DIST_WIDTH   = 32;

	localparam int NODE_W = 10;
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int EIDX_W = $clog2(MAX_EDGES);
	localparam int ELNK_W = EIDX_W + 1;
	localparam int WGT_W  = 16;
	localparam int MAG_W  = 15;

	localparam logic [ELNK_W-1:0] LIST_EMPTY = ELNK_W'(MAX_EDGES);
	localparam logic signed [DIST_WIDTH-1:0] DIST_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
	localparam logic signed [DIST_WIDTH-1:0] DIST_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

	// write command from the loader to the edge store
	typedef struct packed {
		logic              en;
		logic [EIDX_W-1:0] addr;
		logic [NODE_W-1:0] target;
		logic [WGT_W-1:0]  weight;
		logic [ELNK_W-1:0] next;
	} edge_wr_t;

	// read data of the edge store
	typedef struct packed {
		logic [NODE_W-1:0] target;
		logic [WGT_W-1:0]  weight;
		logic [ELNK_W-1:0] next;
	} edge_rd_t;

	// saturating add of a distance and an edge weight
	function automatic logic signed [DIST_WIDTH-1:0] sat_add(
		input logic signed [DIST_WIDTH-1:0] d, input logic signed [WGT_W-1:0] w);
		logic signed [DIST_WIDTH:0] s;
		s = {d[DIST_WIDTH-1], d} + (DIST_WIDTH+1)'(w);
		if (s > (DIST_WIDTH+1)'(DIST_MAX)) return DIST_MAX;
		if (s < (DIST_WIDTH+1)'(DIST_MIN)) return DIST_MIN;
		return s[DIST_WIDTH-1:0];
	endfunction

endpackage

>>> hw/rtl/negative_cycle_detector.sv
// negative_cycle_detector: edge loading and SPFA negative cycle search
// depends on ncd_pkg and ncd_edge_store
//
// channel   signals                                              direction
// config    node_count_we, node_count                            in
// edge      start, from_node, to_node, edge_weight,
//           one_way, edge_present, last_item (busy is out)       in
// result    done, negative_cycle, edge_dropped                   out
//
// after an edge transaction busy stays high through a head read, then a head and
// edge write, per list insert: one insert for a one-way edge, two for a two-way
// edge; a dropped edge or a plain marker that is not the last item leaves busy low.
// the last transaction runs the pass: an init sweep over the effective node count,
// then per dequeued vertex a fifo read and a head read, plus per adjacency entry an
// edge read, a target read and a relax step (only the edge read when the target is
// out of range); the whole head table is then swept, as after reset, with busy high.
// results come as a one-cycle done strobe; the receiver cannot stall.

module negative_cycle_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        node_count_we,
	input  logic [9:0]  node_count,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  from_node,
	input  logic [9:0]  to_node,
	input  logic [14:0] edge_weight,
	input  logic        one_way,
	input  logic        edge_present,
	input  logic        last_item,
	output logic        done,
	output logic        negative_cycle,
	output logic        edge_dropped
);

	localparam int NW = ncd_pkg::NODE_W;
	localparam int VW = ncd_pkg::VIDX_W;
	localparam int EW = ncd_pkg::EIDX_W;
	localparam int LW = ncd_pkg::ELNK_W;
	localparam int DW = ncd_pkg::DIST_WIDTH;
	localparam int CW = VW + 1;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_INS_RD, S_INS_WR, S_INS2_RD, S_INS2_WR,
		S_INIT, S_DEQ, S_DEQ_WAIT, S_HEAD, S_EDGE_WAIT, S_EDGE, S_READ_T,
		S_RELAX, S_REPORT
	} state_t;

	state_t state_q;

	logic [NW-1:0] ncnt_q;
	logic [NW-1:0] neff;
	logic [EW:0]   stored_q;
	logic          dropped_q;

	// latched edge transaction
	logic [NW-1:0]            a_q, b_q;
	logic [ncd_pkg::WGT_W-1:0] w_q;
	logic                     last_q;

	// pass registers
	logic [CW-1:0]  cnt_q, front_q;
	logic [VW-1:0]  sweep_q;
	logic [NW-1:0]  u_q, t_q;
	logic [LW-1:0]  link_q;
	logic signed [DW-1:0] du_q, nd_q;
	logic [NW-1:0]  hu_q;
	logic           neg_q;

	// memories
	logic [LW-1:0]         head_mem [ncd_pkg::MAX_VERTICES];
	logic signed [DW-1:0]  dist_mem [ncd_pkg::MAX_VERTICES];
	logic [NW-1:0]         hop_mem  [ncd_pkg::MAX_VERTICES];
	logic                  qmark_mem[ncd_pkg::MAX_VERTICES];
	logic [NW-1:0]         fifo_mem [ncd_pkg::MAX_VERTICES];

	logic [VW-1:0] head_ra, dist_ra, fifo_ra;
	logic [LW-1:0] head_rd;
	logic signed [DW-1:0] dist_rd;
	logic [NW-1:0] hop_rd, fifo_rd;
	logic          qmark_rd;
	logic          head_we, dist_we, hop_we, qm_we, fifo_we;
	logic [VW-1:0] head_wa, dist_wa, qm_wa, fifo_wa;
	logic [LW-1:0] head_wd;
	logic signed [DW-1:0] dist_wd;
	logic [NW-1:0] hop_wd, fifo_wd;
	logic          qm_wd;

	ncd_pkg::edge_wr_t ewr;
	ncd_pkg::edge_rd_t erd;
	logic [EW-1:0] e_ra;

	ncd_edge_store u_store (.clk(clk), .wr(ewr), .rd_addr(e_ra), .rd(erd));

	// effective node count
	always_comb begin
		if (ncnt_q == '0) neff = NW'(1);
		else if (ncnt_q > NW'(ncd_pkg::MAX_VERTICES)) neff = NW'(ncd_pkg::MAX_VERTICES);
		else neff = ncnt_q;
	end

	function automatic logic in_rng(input logic [NW-1:0] v, input logic [NW-1:0] n);
		return (v != '0) && (v <= n);
	endfunction

	// vertex v lives at v-1
	function automatic logic [VW-1:0] vidx(input logic [NW-1:0] v);
		logic [NW-1:0] m;
		m = v - NW'(1);
		return m[VW-1:0];
	endfunction

	logic take;
	assign take = start && !busy;
	assign busy = (state_q != S_IDLE);

	logic signed [DW-1:0] nd_c;
	assign nd_c = ncd_pkg::sat_add(du_q, erd.weight);
	logic [NW-1:0] hop_new;
	assign hop_new = hu_q + NW'(1);
	logic [CW-1:0] tail;
	assign tail = front_q + cnt_q;

	// memory address and write control
	always_comb begin
		head_ra = vidx(a_q);
		dist_ra = vidx(u_q);
		fifo_ra = front_q[VW-1:0];
		e_ra    = link_q[EW-1:0];
		head_we = 1'b0; head_wa = vidx(a_q); head_wd = ncd_pkg::LIST_EMPTY;
		dist_we = 1'b0; dist_wa = sweep_q; dist_wd = '0;
		hop_we = 1'b0; hop_wd = '0;
		qm_we = 1'b0; qm_wa = sweep_q; qm_wd = 1'b1;
		fifo_we = 1'b0; fifo_wa = sweep_q; fifo_wd = NW'(sweep_q) + NW'(1);
		ewr = '0;
		case (state_q)
			S_CLEAR: begin
				head_we = 1'b1; head_wa = sweep_q;
			end
			S_IDLE: head_ra = vidx(from_node);
			S_INS_WR: begin
				head_we = 1'b1; head_wd = LW'(stored_q);
				ewr = '{en: 1'b1, addr: stored_q[EW-1:0], target: b_q, weight: w_q,
					next: head_rd};
				head_ra = vidx(b_q);
			end
			S_INS2_RD: head_ra = vidx(b_q);
			S_INS2_WR: begin
				head_we = 1'b1; head_wa = vidx(b_q); head_wd = LW'(stored_q);
				ewr = '{en: 1'b1, addr: stored_q[EW-1:0], target: a_q, weight: w_q,
					next: head_rd};
			end
			S_INIT: begin
				dist_we = 1'b1; hop_we = 1'b1; qm_we = 1'b1; fifo_we = 1'b1;
			end
			S_DEQ_WAIT: begin
				head_ra = vidx(fifo_rd);
				dist_ra = vidx(fifo_rd);
				if (in_rng(fifo_rd, neff)) begin
					qm_we = 1'b1; qm_wa = vidx(fifo_rd); qm_wd = 1'b0;
				end
			end
			S_EDGE: dist_ra = vidx(erd.target);
			// hold the target address so its data is still there in relax
			S_READ_T: dist_ra = vidx(t_q);
			S_RELAX: begin
				if (nd_q < dist_rd) begin
					dist_we = 1'b1; dist_wa = vidx(t_q); dist_wd = nd_q;
					hop_we = 1'b1; hop_wd = hop_new;
					if (!qmark_rd && cnt_q < CW'(ncd_pkg::MAX_VERTICES)) begin
						qm_we = 1'b1; qm_wa = vidx(t_q); qm_wd = 1'b1;
						fifo_we = 1'b1; fifo_wa = tail[VW-1:0]; fifo_wd = t_q;
					end
				end
			end
			S_REPORT: begin
				head_we = 1'b1; head_wa = sweep_q;
			end
			default: ;
		endcase
	end

	// state memories, registered reads
	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd <= head_mem[head_ra];
		if (dist_we) dist_mem[dist_wa] <= dist_wd;
		if (hop_we) hop_mem[dist_wa] <= hop_wd;
		dist_rd  <= dist_mem[dist_ra];
		hop_rd   <= hop_mem[dist_ra];
		if (qm_we) qmark_mem[qm_wa] <= qm_wd;
		qmark_rd <= qmark_mem[dist_ra];
		if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
		fifo_rd <= fifo_mem[fifo_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ncnt_q <= NW'(1);
			stored_q <= '0;
			dropped_q <= 1'b0;
			sweep_q <= '0;
			cnt_q <= '0;
			front_q <= '0;
			neg_q <= 1'b0;
			done <= 1'b0;
			negative_cycle <= 1'b0;
			edge_dropped <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			w_q <= '0;
			last_q <= 1'b0;
			u_q <= '0;
			t_q <= '0;
			link_q <= '0;
			du_q <= '0;
			nd_q <= '0;
			hu_q <= '0;
		end else begin
			done <= 1'b0;
			if (node_count_we) ncnt_q <= node_count;
			case (state_q)
				S_CLEAR, S_REPORT: begin
					if (state_q == S_REPORT && sweep_q == '0) begin
						done <= 1'b1;
						negative_cycle <= neg_q;
						edge_dropped <= dropped_q;
						stored_q <= '0;
						dropped_q <= 1'b0;
					end
					sweep_q <= sweep_q + VW'(1);
					if (sweep_q == VW'(ncd_pkg::MAX_VERTICES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (take) begin
					a_q <= from_node; b_q <= to_node; last_q <= last_item;
					w_q <= one_way ? -ncd_pkg::WGT_W'(edge_weight)
						: ncd_pkg::WGT_W'(edge_weight);
					sweep_q <= '0;
					if (edge_present && (!in_rng(from_node, neff) || !in_rng(to_node, neff)
						|| stored_q + (EW+1)'(one_way ? 1 : 2) > (EW+1)'(ncd_pkg::MAX_EDGES))) begin
						dropped_q <= 1'b1;
						state_q <= last_item ? S_INIT : S_IDLE;
					end else if (edge_present) begin
						state_q <= one_way ? S_INS_RD : S_INS_RD;
						neg_q <= one_way;
					end else begin
						state_q <= last_item ? S_INIT : S_IDLE;
					end
				end
				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					stored_q <= stored_q + (EW+1)'(1);
					if (!neg_q) state_q <= S_INS2_RD;
					else state_q <= last_q ? S_INIT : S_IDLE;
				end
				S_INS2_RD: state_q <= S_INS2_WR;
				S_INS2_WR: begin
					stored_q <= stored_q + (EW+1)'(1);
					state_q <= last_q ? S_INIT : S_IDLE;
				end
				S_INIT: begin
					sweep_q <= sweep_q + VW'(1);
					if (NW'(sweep_q) + NW'(1) == neff) begin
						cnt_q <= CW'(neff);
						front_q <= '0;
						neg_q <= 1'b0;
						state_q <= S_DEQ;
					end
				end
				S_DEQ: begin
					if (cnt_q == '0) begin
						sweep_q <= '0;
						state_q <= S_REPORT;
					end else state_q <= S_DEQ_WAIT;
				end
				S_DEQ_WAIT: begin
					u_q <= fifo_rd;
					front_q <= CW'(front_q[VW-1:0]) + CW'(1);
					cnt_q <= cnt_q - CW'(1);
					state_q <= in_rng(fifo_rd, neff) ? S_HEAD : S_DEQ;
				end
				S_HEAD: begin
					link_q <= head_rd;
					du_q <= dist_rd;
					hu_q <= hop_rd;
					state_q <= (head_rd == ncd_pkg::LIST_EMPTY) ? S_DEQ : S_EDGE_WAIT;
				end
				S_EDGE_WAIT: state_q <= S_EDGE;
				S_EDGE: begin
					t_q <= erd.target;
					nd_q <= nd_c;
					link_q <= erd.next;
					state_q <= in_rng(erd.target, neff) ? S_READ_T : S_RELAX;
					if (!in_rng(erd.target, neff)) begin
						state_q <= (erd.next == ncd_pkg::LIST_EMPTY) ? S_DEQ : S_EDGE_WAIT;
					end
				end
				S_READ_T: state_q <= S_RELAX;
				S_RELAX: begin
					if (nd_q < dist_rd) begin
						if (t_q == u_q) begin
							du_q <= nd_q; hu_q <= hop_new;
						end
						if (hop_new >= neff) begin
							neg_q <= 1'b1;
							sweep_q <= '0;
							state_q <= S_REPORT;
						end else begin
							if (!qmark_rd && cnt_q < CW'(ncd_pkg::MAX_VERTICES))
								cnt_q <= cnt_q + CW'(1);
							state_q <= (link_q == ncd_pkg::LIST_EMPTY) ? S_DEQ : S_EDGE_WAIT;
						end
					end else begin
						state_q <= (link_q == ncd_pkg::LIST_EMPTY) ? S_DEQ : S_EDGE_WAIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result is only reported from the clearing sweep after a pass
	a_done_report: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_REPORT)
		else $error("result strobe outside report");
	// no transaction is taken while the head table is being cleared
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR || state_q == S_REPORT) |-> busy)
		else $error("busy low during clear sweep");
	// fifo occupancy never exceeds its depth
	a_fifo_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ncd_pkg::MAX_VERTICES))
		else $error("vertex fifo overflow");

endmodule

>>> hw/rtl/ncd_edge_store.sv
// ncd_edge_store: edge memory (target, weight, next link), one write and one read port
// depends on ncd_pkg

module ncd_edge_store (
	input  logic                      clk,
	input  ncd_pkg::edge_wr_t         wr,
	input  logic [ncd_pkg::EIDX_W-1:0] rd_addr,
	output ncd_pkg::edge_rd_t         rd
);

	ncd_pkg::edge_rd_t mem [ncd_pkg::MAX_EDGES];

	// synchronous write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= '{target: wr.target, weight: wr.weight, next: wr.next};
		end
		rd <= mem[rd_addr];
	end

endmodule
